### src/scope_edge_trigger_search_unit_macros.svh
// ----------------------------------------------------------------------------
// Edge trigger search unit: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCOPE_EDGE_TRIGGER_SEARCH_UNIT_MACROS_SVH
`define SCOPE_EDGE_TRIGGER_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication
`define SETU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SETU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/setu_pkg.sv
// ----------------------------------------------------------------------------
// Edge trigger search unit: package
// Transaction types, configuration codes and search phases.
// ----------------------------------------------------------------------------
package setu_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OFFSET_W = 16;  // sample index wraps at 65536 samples
  localparam int RUN_W    = 16;
  localparam int LEVEL_W  = 16;
  localparam int TOL_W    = 15;
  localparam int MODE_W   = 2;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 16;
  localparam int CMP_W    = LEVEL_W + 2;  // level +/- tolerance without overflow

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // trigger modes
  localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RISE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FALL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEVER = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LEVEL   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TOL     = 2'd2;
  localparam logic [CIDX_W-1:0] REG_MIN_RUN = 2'd3;

  // reset values
  localparam logic [MODE_W-1:0]  MODE_RST    = MODE_RISE;
  localparam logic [RUN_W-1:0]   MIN_RUN_RST = 16'd10;

  typedef enum logic [1:0] {
    PH_ARM  = 2'd0,
    PH_SEEK = 2'd1,
    PH_RUN  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } out_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [LEVEL_W-1:0] level;
    logic [TOL_W-1:0]          tol;
    logic [RUN_W-1:0]          min_run;
  } cfg_t;

endpackage

### src/setu_cfg_regs.sv
// ----------------------------------------------------------------------------
// Edge trigger search unit: configuration registers
// Write-only register file; always ready.
// ----------------------------------------------------------------------------
module setu_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [setu_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [setu_pkg::CDATA_W-1:0] cfg_data,
  output setu_pkg::cfg_t          cfg
);
  import setu_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:    cfg_nxt.mode    = cfg_data[MODE_W-1:0];
        REG_LEVEL:   cfg_nxt.level   = cfg_data[LEVEL_W-1:0];
        REG_TOL:     cfg_nxt.tol     = cfg_data[TOL_W-1:0];
        REG_MIN_RUN: cfg_nxt.min_run = cfg_data[RUN_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= MODE_RST;
      cfg_r.level   <= '0;
      cfg_r.tol     <= '0;
      cfg_r.min_run <= MIN_RUN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/setu_in_stage.sv
// ----------------------------------------------------------------------------
// Edge trigger search unit: input register
// Holds one sample transaction until the search core consumes it.
// ----------------------------------------------------------------------------
module setu_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  setu_pkg::in_t in_data,
  output logic          item_vld,
  output setu_pkg::in_t item,
  input  logic          adv
);
  import setu_pkg::*;

  logic vld_r, vld_nxt;
  in_t  data_r, data_nxt;
  logic take;

  assign in_stall = vld_r && !adv;
  assign take     = in_valid && !in_stall;
  assign item_vld = vld_r;
  assign item     = data_r;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (take) begin
      vld_nxt  = 1'b1;
      data_nxt = in_data;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### src/setu_search_core.sv
// ----------------------------------------------------------------------------
// Edge trigger search unit: search core
// Per-sample trigger decision and capture state.
// ----------------------------------------------------------------------------
`include "scope_edge_trigger_search_unit_macros.svh"

module setu_search_core (
  input  logic           clk,
  input  logic           rst_n,
  input  setu_pkg::cfg_t cfg,
  input  logic           item_vld,
  input  setu_pkg::in_t  item,
  input  logic           out_free,
  output logic           adv,
  output logic           res_vld,
  output setu_pkg::out_t res
);
  import setu_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [OFFSET_W-1:0] idx_r, idx_nxt;
  logic [RUN_W-1:0]    run_len_r, run_len_nxt;
  logic [OFFSET_W-1:0] run_start_r, run_start_nxt;
  logic                pol_r, pol_nxt;

  logic signed [CMP_W-1:0] s_x, lvl_x, tol_x, arm_lo, arm_hi;
  logic ge, le, armed, past, hit;
  logic [OFFSET_W-1:0] pos;

  assign s_x    = {{(CMP_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
  assign lvl_x  = {{(CMP_W-LEVEL_W){cfg.level[LEVEL_W-1]}}, cfg.level};
  assign tol_x  = {{(CMP_W-TOL_W){1'b0}}, cfg.tol};
  assign arm_lo = lvl_x - tol_x;
  assign arm_hi = lvl_x + tol_x;
  assign ge     = s_x >= lvl_x;
  assign le     = s_x <= lvl_x;
  assign armed  = (cfg.mode == MODE_RISE) ? (s_x <= arm_lo) : (s_x >= arm_hi);
  assign past   = (cfg.mode == MODE_RISE) ? ge : le;

  always_comb begin
    phase_t ph;
    logic   pol;
    ph            = phase_r;
    pol           = pol_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    pol_nxt       = pol_r;
    hit           = 1'b0;
    pos           = '0;

    if (phase_r != PH_DONE) begin
      case (cfg.mode)
        MODE_BOTH: begin
          if (phase_r == PH_ARM) begin
            pol       = ge;
            pol_nxt   = ge;
            phase_nxt = PH_SEEK;
          end
          if (le == pol) begin
            hit = 1'b1;
            pos = idx_r;
          end
        end
        MODE_RISE, MODE_FALL: begin
          if (ph == PH_ARM && armed) begin
            ph = PH_SEEK;
          end
          phase_nxt = ph;
          if (ph == PH_SEEK) begin
            if (past) begin
              run_start_nxt = idx_r;
              run_len_nxt   = RUN_W'(1);
              phase_nxt     = PH_RUN;
            end
          end else if (ph == PH_RUN) begin
            if (past) begin
              if (run_len_r != RUN_MAX) begin
                run_len_nxt = run_len_r + RUN_W'(1);
              end
            end else if (run_len_r >= cfg.min_run) begin
              hit = 1'b1;
              pos = run_start_r;
            end else begin
              run_len_nxt = '0;
              phase_nxt   = PH_SEEK;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    if (hit) begin
      phase_nxt = PH_DONE;
    end

    if (item.last) begin
      phase_nxt     = PH_ARM;
      idx_nxt       = '0;
      run_len_nxt   = '0;
      run_start_nxt = '0;
      pol_nxt       = 1'b0;
    end else begin
      idx_nxt = idx_r + OFFSET_W'(1);
    end
  end

  // a done phase means this capture already reported
  assign res_vld    = item_vld && (hit || (item.last && phase_r != PH_DONE));
  assign res.found  = hit;
  assign res.offset = hit ? pos : '0;
  assign adv        = item_vld && (out_free || !res_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ARM;
      idx_r       <= '0;
      run_len_r   <= '0;
      run_start_r <= '0;
      pol_r       <= 1'b0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      run_len_r   <= run_len_nxt;
      run_start_r <= run_start_nxt;
      pol_r       <= pol_nxt;
    end
  end

  `SETU_ASSERT_IMPL(a_miss_only_on_last, adv && res_vld && !res.found, item.last,
                    "not-found result on a sample other than the last")
  `SETU_ASSERT_IMPL(a_miss_zero_offset, res_vld && !res.found, res.offset == '0,
                    "not-found result carries a nonzero offset")
  `SETU_ASSERT_NEXT(a_last_clears, adv && item.last,
                    phase_r == PH_ARM && idx_r == '0 && run_len_r == '0,
                    "capture state not cleared after last sample")
  `SETU_ASSERT_IMPL(a_arm_no_run, phase_r == PH_ARM, run_len_r == '0,
                    "run length held while arming")

endmodule

### src/setu_out_stage.sv
// ----------------------------------------------------------------------------
// Edge trigger search unit: result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module setu_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  setu_pkg::out_t res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_stall,
  output setu_pkg::out_t out_data
);
  import setu_pkg::*;

  logic vld_r, vld_nxt;
  out_t data_r, data_nxt;

  assign out_free  = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (load) begin
      vld_nxt  = 1'b1;
      data_nxt = res;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### src/scope_edge_trigger_search_unit.sv
// ----------------------------------------------------------------------------
// Scope edge trigger search unit
// Path: a sample accepted into the input register shows its result on out_valid
// once the core has loaded that result into the result register.
// Throughput: one sample per cycle unless a result waits on the result register.
// Reset: synchronous, active low; clears capture state, loads register defaults.
// ----------------------------------------------------------------------------
module scope_edge_trigger_search_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample stream
  input  logic                         in_valid,
  output logic                         in_stall,
  input  setu_pkg::in_t                in_data,
  // one result per capture
  output logic                         out_valid,
  input  logic                         out_stall,
  output setu_pkg::out_t               out_data,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [setu_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [setu_pkg::CDATA_W-1:0] cfg_data
);
  import setu_pkg::*;

  cfg_t cfg;
  in_t  item;
  out_t res;
  logic item_vld;
  logic adv;
  logic res_vld;
  logic out_free;

  // Mode, level, hysteresis, minimum run; write only while idle (not enforced).
  setu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register. It drains whenever the core consumes the held sample, so
  // a new transaction is taken in the same cycle the old one moves on.
  setu_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .item_vld (item_vld),
    .item     (item),
    .adv      (adv)
  );

  // Search core: compares against level and level +/- tolerance, tracks the
  // arm / seek / run / done phase, sample index and run length. A sample that
  // produces no result moves on even while the result register is blocked;
  // only a sample that produces a result waits for a free slot.
  setu_search_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_vld (item_vld),
    .item     (item),
    .out_free (out_free),
    .adv      (adv),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Result register: found flag and trigger offset, one per capture.
  setu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
